[rtl/yaz0_pkg.sv]
package yaz0_pkg;

  localparam int WindowBytes = 4096;
  localparam int WinAw = $clog2(WindowBytes);
  localparam int OutLanes = 8;
  localparam int SizeW = 27;
  localparam int HdrLen = 16;
  localparam logic [31:0] MaxOutputBytes = 32'd67108864;
  localparam int QDepth = 4;
  localparam int QAw = $clog2(QDepth);

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_HEADER = 3'd1;
  localparam logic [2:0] ST_SIZE = 3'd2;
  localparam logic [2:0] ST_DIST = 3'd3;
  localparam logic [2:0] ST_TRUNC = 3'd4;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LIT,
    OP_COPY
  } op_t;

  // One command from the front part to the back part.
  typedef struct packed {
    op_t              op;
    logic [7:0]       lit;
    logic [WinAw-1:0] offset;
    logic [8:0]       len;
    logic             fin;
    logic [2:0]       st;
    logic [SizeW-1:0] size;
  } cmd_t;

endpackage

[rtl/yaz0_lz_stream_decoder.sv]
// Channel | Direction | Handshake           | Payload
// src     | in        | src_valid/src_stall | src_byte, src_last
// out     | out       | valid/stall         | out_bytes, out_count, item_last,
//         |           |                     | stream_end, status, decoded_size
// The front takes one source byte a cycle while the four-entry command queue has room.
// In the back a literal is written to the history RAM and goes to the output register;
// a copy goes byte by byte: each byte is a registered read of the history RAM and
// then its write, and every pack of up to eight bytes goes to the output register.
// A status transaction is a further output item; stall on the result holds the back part.
// rst is synchronous; the history RAM is not cleared.
module yaz0_lz_stream_decoder import yaz0_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  src_byte,
  input  logic        src_last,
  output logic        valid,
  input  logic        stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_count,
  output logic        item_last,
  output logic        stream_end,
  output logic [2:0]  status,
  output logic [26:0] decoded_size
);

  cmd_t        f_cmd;
  logic        f_valid;
  cmd_t        q [QDepth];
  logic [QAw:0] cnt;
  logic [QAw-1:0] rp;
  logic [QAw-1:0] wp;
  logic        pop;
  logic        full;

  assign full = (cnt == (QAw+1)'(QDepth));

  yaz0_front u_front (
    .clk(clk), .rst(rst), .src_valid(src_valid), .src_stall(src_stall),
    .src_byte(src_byte), .src_last(src_last), .cmd_valid(f_valid), .cmd(f_cmd),
    .cmd_full(full)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rp <= '0;
      wp <= '0;
    end else begin
      if (f_valid) begin
        q[wp] <= f_cmd;
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (QAw+1)'(f_valid) - (QAw+1)'(pop);
    end
  end

  yaz0_back u_back (
    .clk(clk), .rst(rst), .q_valid(cnt != '0), .q_cmd(q[rp]), .q_pop(pop),
    .valid(valid), .stall(stall), .out_bytes(out_bytes), .out_count(out_count),
    .item_last(item_last), .stream_end(stream_end), .status(status),
    .decoded_size(decoded_size)
  );

endmodule

[rtl/yaz0_ram.sv]
module yaz0_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/yaz0_front.sv]
module yaz0_front import yaz0_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_stall,
  input  logic [7:0] src_byte,
  input  logic       src_last,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_full
);

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_REF2,
    PH_REF3
  } phase_t;

  logic [4:0]  header_index;
  logic [31:0] target_size;
  logic [26:0] bytes_produced;
  logic [7:0]  flag_byte;
  logic [3:0]  flag_bits_left;
  phase_t      token_phase;
  logic [7:0]  first_ref_byte;
  logic [7:0]  second_ref_byte;
  logic [2:0]  stream_status;

  logic [7:0]       magic;
  logic             fire;
  logic             go;
  logic [26:0]      remain;
  logic [8:0]       want;
  logic [8:0]       n;
  logic             do_copy;
  logic             bad;
  logic [WinAw-1:0] offset;
  logic [2:0]       st_f;
  logic [31:0]      ts_next;
  op_t              op;
  logic [26:0]      bp;

  assign src_stall = cmd_full;
  assign fire = src_valid && !cmd_full;
  assign go = (header_index == 5'(HdrLen)) && stream_status == ST_OK &&
              {5'd0, bytes_produced} < target_size;
  assign remain = target_size[26:0] - bytes_produced;

  always_comb begin
    unique case (header_index[1:0])
      2'd0: magic = 8'h59;
      2'd1: magic = 8'h61;
      2'd2: magic = 8'h7A;
      default: magic = 8'h30;
    endcase
  end

  always_comb begin
    do_copy = 1'b0;
    want = '0;
    offset = '0;
    if (go && token_phase == PH_REF2 && first_ref_byte[7:4] != 4'd0) begin
      do_copy = 1'b1;
      want = 9'(first_ref_byte[7:4]) + 9'd2;
      offset = {first_ref_byte[3:0], src_byte};
    end else if (go && token_phase == PH_REF3) begin
      do_copy = 1'b1;
      want = 9'(src_byte) + 9'h12;
      offset = {first_ref_byte[3:0], second_ref_byte};
    end
    bad = do_copy && ({15'd0, offset} >= bytes_produced);
    n = (27'(want) > remain) ? remain[8:0] : want;
  end

  always_comb begin
    ts_next = target_size;
    if (header_index >= 5'd4 && header_index < 5'd8) begin
      ts_next = {target_size[23:0], src_byte};
    end
    st_f = stream_status;
    if (header_index < 5'd4 && src_byte != magic && stream_status == ST_OK) begin
      st_f = ST_HEADER;
    end
    if (header_index == 5'(HdrLen - 1) && st_f == ST_OK && ts_next > MaxOutputBytes) begin
      st_f = ST_SIZE;
    end
    if (bad) begin
      st_f = ST_DIST;
    end
  end

  always_comb begin
    op = OP_NONE;
    if (do_copy && !bad) begin
      op = OP_COPY;
    end else if (go && token_phase == PH_TOKEN && flag_bits_left != 4'd0 && flag_byte[7]) begin
      op = OP_LIT;
    end
    bp = bytes_produced + ((op == OP_COPY) ? 27'(n) : (op == OP_LIT) ? 27'd1 : 27'd0);
    cmd = '0;
    cmd.op = op;
    cmd.offset = offset;
    cmd.len = n;
    cmd.lit = src_byte;
    cmd.fin = src_last;
    cmd.st = st_f;
    if (header_index < 5'(HdrLen - 1)) begin
      cmd.st = ST_HEADER;
    end else if (st_f == ST_OK) begin
      if (header_index != 5'(HdrLen)) begin
        cmd.st = (ts_next != 32'd0) ? ST_TRUNC : ST_OK;
      end else begin
        cmd.st = ({5'd0, bp} < target_size) ? ST_TRUNC : ST_OK;
      end
    end
    cmd.size = (cmd.st == ST_HEADER || cmd.st == ST_SIZE) ? '0 : ts_next[26:0];
    cmd_valid = fire && (op != OP_NONE || src_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index <= '0;
      target_size <= '0;
      bytes_produced <= '0;
      flag_byte <= '0;
      flag_bits_left <= '0;
      token_phase <= PH_TOKEN;
      first_ref_byte <= '0;
      second_ref_byte <= '0;
      stream_status <= ST_OK;
    end else if (fire) begin
      if (src_last) begin
        header_index <= '0;
        target_size <= '0;
        bytes_produced <= '0;
        flag_byte <= '0;
        flag_bits_left <= '0;
        token_phase <= PH_TOKEN;
        first_ref_byte <= '0;
        second_ref_byte <= '0;
        stream_status <= ST_OK;
      end else if (header_index != 5'(HdrLen)) begin
        header_index <= header_index + 5'd1;
        target_size <= ts_next;
        stream_status <= st_f;
      end else if (go) begin
        stream_status <= st_f;
        unique case (token_phase)
          PH_REF2: begin
            second_ref_byte <= src_byte;
            if (!do_copy) begin
              token_phase <= PH_REF3;
            end
          end
          PH_TOKEN: begin
            if (flag_bits_left == 4'd0) begin
              flag_byte <= src_byte;
              flag_bits_left <= 4'd8;
            end else if (!flag_byte[7]) begin
              first_ref_byte <= src_byte;
              token_phase <= PH_REF2;
            end
          end
          default: begin
          end
        endcase
        if (op == OP_LIT) begin
          bytes_produced <= bytes_produced + 27'd1;
        end else if (op == OP_COPY) begin
          bytes_produced <= bytes_produced + 27'(n);
        end
        if (op != OP_NONE) begin
          flag_byte <= {flag_byte[6:0], 1'b0};
          flag_bits_left <= flag_bits_left - 4'd1;
          token_phase <= PH_TOKEN;
        end
      end
    end
  end

endmodule

[rtl/yaz0_back.sv]
module yaz0_back import yaz0_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        valid,
  input  logic        stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_count,
  output logic        item_last,
  output logic        stream_end,
  output logic [2:0]  status,
  output logic [26:0] decoded_size
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WAIT,
    S_FLUSH,
    S_STATUS
  } state_t;

  state_t           state;
  logic [WinAw-1:0] wptr;
  logic [WinAw-1:0] offset;
  logic [8:0]       left;
  logic [63:0]      acc;
  logic [3:0]       lanes;
  logic             fin;
  logic [2:0]       fin_st;
  logic [SizeW-1:0] fin_size;
  logic             out_free;
  logic             load;
  logic             we;
  logic [7:0]       wbyte;
  logic [WinAw-1:0] raddr;
  logic [7:0]       rdata;

  assign out_free = !valid || !stall;
  assign load = out_free && (state == S_FLUSH || state == S_STATUS);
  assign q_pop = (state == S_IDLE) && q_valid;
  assign we = (q_pop && q_cmd.op == OP_LIT) || state == S_WAIT;
  assign wbyte = (state == S_WAIT) ? rdata : q_cmd.lit;
  // Read one byte behind the write pointer by the copy offset.
  assign raddr = wptr - offset - WinAw'(1);

  yaz0_ram #(.Width(8), .Depth(WindowBytes)) u_win (
    .clk(clk), .we(we), .waddr(wptr), .wdata(wbyte), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wptr <= '0;
      offset <= '0;
      left <= '0;
      acc <= '0;
      lanes <= '0;
      fin <= 1'b0;
      fin_st <= ST_OK;
      fin_size <= '0;
      valid <= 1'b0;
      out_bytes <= '0;
      out_count <= '0;
      item_last <= 1'b0;
      stream_end <= 1'b0;
      status <= ST_OK;
      decoded_size <= '0;
    end else begin
      if (load) begin
        valid <= 1'b1;
      end else if (!stall) begin
        valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            fin <= q_cmd.fin;
            fin_st <= q_cmd.st;
            fin_size <= q_cmd.size;
            offset <= q_cmd.offset;
            unique case (q_cmd.op)
              OP_LIT: begin
                wptr <= wptr + WinAw'(1);
                acc <= {56'd0, q_cmd.lit};
                lanes <= 4'd1;
                left <= '0;
                state <= S_FLUSH;
              end
              OP_COPY: begin
                acc <= '0;
                lanes <= '0;
                left <= q_cmd.len;
                state <= S_READ;
              end
              default: begin
                acc <= '0;
                lanes <= '0;
                left <= '0;
                state <= S_STATUS;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          wptr <= wptr + WinAw'(1);
          acc[{lanes[2:0], 3'd0} +: 8] <= rdata;
          lanes <= lanes + 4'd1;
          left <= left - 9'd1;
          if (lanes == 4'(OutLanes - 1) || left == 9'd1) begin
            state <= S_FLUSH;
          end else begin
            state <= S_READ;
          end
        end
        S_FLUSH: begin
          if (load) begin
            out_bytes <= acc;
            out_count <= lanes;
            item_last <= left == 9'd0 && !fin;
            stream_end <= 1'b0;
            status <= ST_OK;
            decoded_size <= '0;
            acc <= '0;
            lanes <= '0;
            if (left != 9'd0) begin
              state <= S_READ;
            end else if (fin) begin
              state <= S_STATUS;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_STATUS: begin
          if (load) begin
            out_bytes <= '0;
            out_count <= '0;
            item_last <= 1'b1;
            stream_end <= 1'b1;
            status <= fin_st;
            decoded_size <= fin_size;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
